### rtl/i2cmbe_pkg.sv
// Shared types, command codes and last-phase indices for the I2C master byte engine.
package i2cmbe_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic {
    BACK_IDLE = 1'b0,
    BACK_RUN  = 1'b1
  } back_state_t;

  typedef struct packed {
    cmd_t       kind;
    logic [7:0] octet;
    logic       ack_bit;
    logic       nack;
    logic [7:0] rdata;
  } desc_t;

  localparam int PHASE_W = 5;

  localparam logic [PHASE_W-1:0] LAST_START = PHASE_W'(19);
  localparam logic [PHASE_W-1:0] LAST_WRITE = PHASE_W'(17);
  localparam logic [PHASE_W-1:0] LAST_READ  = PHASE_W'(18);
  localparam logic [PHASE_W-1:0] LAST_STOP  = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] START_LEAD = PHASE_W'(2);

  localparam logic [7:0] HOLD_RESET = 8'd16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ADDR_PHASE_HOLD = 3'd0;

endpackage

### rtl/i2cmbe_front.sv
// Command front end: classify each command into a descriptor and queue it.
module i2cmbe_front import i2cmbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [6:0] slave_address,
  input  logic       read_not_write,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic [8:0] bus_sda,
  output logic       q_valid,
  input  logic       q_pop,
  output desc_t      q_head
);

  desc_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  desc_t             desc_in;
  logic              push;
  logic              pop;

  always_comb begin
    desc_in.kind    = cmd_t'(cmd);
    desc_in.octet   = (cmd_t'(cmd) == CMD_START) ? {slave_address, read_not_write} : tx_byte;
    desc_in.ack_bit = ~send_ack;
    desc_in.nack    = 1'b0;
    desc_in.rdata   = 8'd0;
    case (cmd_t'(cmd))
      CMD_START, CMD_WRITE: begin
        desc_in.nack = bus_sda[8];
      end
      CMD_READ: begin
        desc_in.rdata = bus_sda[7:0];
      end
      default: begin
        desc_in.nack = 1'b0;
      end
    endcase
  end

  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_head   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= desc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/i2cmbe_back.sv
// Phase sequencer: walk the bus phases of each queued command, hold each phase, emit beats.
module i2cmbe_back import i2cmbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] phase_hold_ticks,
  input  logic       q_valid,
  output logic       q_pop,
  input  desc_t      q_head,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_level,
  output logic       sda_level,
  output logic       ack_received,
  output logic [7:0] read_data,
  output logic       last
);

  back_state_t        state;
  back_state_t        state_next;
  desc_t              desc;
  desc_t              desc_next;
  logic [PHASE_W-1:0] idx;
  logic [PHASE_W-1:0] idx_next;
  logic [7:0]         hold;
  logic [7:0]         hold_next;
  logic               out_valid_next;
  logic               scl_next;
  logic               sda_next;
  logic               ack_next;
  logic [7:0]         rdata_next;
  logic               last_next;
  logic [PHASE_W-1:0] pos;
  logic               bit_val;
  logic               ph_scl;
  logic               ph_sda;
  logic               ph_last;
  logic               load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BACK_IDLE;
      out_valid <= 1'b0;
      hold      <= '0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      hold      <= hold_next;
      idx       <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    desc         <= desc_next;
    scl_level    <= scl_next;
    sda_level    <= sda_next;
    ack_received <= ack_next;
    read_data    <= rdata_next;
    last         <= last_next;
  end

  always_comb begin
    pos     = (desc.kind == CMD_START) ? (idx - START_LEAD) : idx;
    bit_val = desc.octet[~pos[3:1]];
    ph_scl  = pos[0];
    ph_sda  = 1'b1;
    ph_last = 1'b0;
    case (desc.kind)
      CMD_START: begin
        ph_last = (idx == LAST_START);
        if (idx == '0) begin
          ph_scl = 1'b1;
          ph_sda = 1'b1;
        end else if (idx == PHASE_W'(1)) begin
          ph_scl = 1'b1;
          ph_sda = 1'b0;
        end else if (!pos[4]) begin
          ph_sda = bit_val;
        end
      end
      CMD_WRITE: begin
        ph_last = (idx == LAST_WRITE);
        if (!pos[4]) begin
          ph_sda = bit_val;
        end
      end
      CMD_READ: begin
        ph_last = (idx == LAST_READ);
        if (pos[4] && (pos[3:1] == 3'd0)) begin
          ph_sda = desc.ack_bit;
        end else if (pos[4]) begin
          ph_scl = 1'b0;
        end
      end
      default: begin
        ph_last = (idx == LAST_STOP);
        ph_scl  = (idx != '0);
        ph_sda  = (idx == LAST_STOP);
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    desc_next      = desc;
    idx_next       = idx;
    hold_next      = (hold != '0) ? (hold - 8'd1) : hold;
    out_valid_next = out_valid && !out_ready;
    scl_next       = scl_level;
    sda_next       = sda_level;
    ack_next       = ack_received;
    rdata_next     = read_data;
    last_next      = last;
    q_pop          = 1'b0;
    load           = 1'b0;
    case (state)
      BACK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          desc_next  = q_head;
          idx_next   = '0;
          state_next = BACK_RUN;
        end
      end
      BACK_RUN: begin
        load = (hold == '0) && (!out_valid || out_ready);
        if (load) begin
          out_valid_next = 1'b1;
          scl_next       = ph_scl;
          sda_next       = ph_sda;
          ack_next       = ph_last ? desc.nack : 1'b0;
          rdata_next     = ph_last ? desc.rdata : 8'd0;
          last_next      = ph_last;
          hold_next      = (phase_hold_ticks != '0) ? (phase_hold_ticks - 8'd1) : '0;
          idx_next       = idx + PHASE_W'(1);
          if (ph_last) begin
            state_next = BACK_IDLE;
          end
        end
      end
      default: begin
        state_next = BACK_IDLE;
      end
    endcase
  end

endmodule

### rtl/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: register port, command front end, phase sequencer.
// Each command is walked as phase beats: start 20, write 18, read 19, stop 3 phases; the
// spacing between beats is set by phase_hold_ticks, and beats stall while out_ready is low.
// The sequencer returns to idle between commands.
// A 2-entry command queue lets new commands enter while the sequencer works.
// Synchronous reset empties the queue and output and sets phase_hold_ticks to 16.
module i2c_master_byte_engine_core import i2cmbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [6:0]  slave_address,
  input  logic        read_not_write,
  input  logic [7:0]  tx_byte,
  input  logic        send_ack,
  input  logic [8:0]  bus_sda,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_level,
  output logic        ack_received,
  output logic [7:0]  read_data,
  output logic        last
);

  logic [7:0] phase_hold_ticks;
  logic       q_valid;
  logic       q_pop;
  desc_t      q_head;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_PHASE_HOLD) ? {24'd0, phase_hold_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_hold_ticks <= HOLD_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_PHASE_HOLD)) begin
      phase_hold_ticks <= pwdata[7:0];
    end
  end

  i2cmbe_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .slave_address  (slave_address),
    .read_not_write (read_not_write),
    .tx_byte        (tx_byte),
    .send_ack       (send_ack),
    .bus_sda        (bus_sda),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_head         (q_head)
  );

  i2cmbe_back u_back (
    .clk              (clk),
    .rst              (rst),
    .phase_hold_ticks (phase_hold_ticks),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_head           (q_head),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .scl_level        (scl_level),
    .sda_level        (sda_level),
    .ack_received     (ack_received),
    .read_data        (read_data),
    .last             (last)
  );

endmodule

### tb/tb_i2c_master_byte_engine_core.sv
// Testbench for the I2C master byte engine: command driver, phase monitor and predictor.
module tb_i2c_master_byte_engine_core import i2cmbe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    cmd_t       kind;
    logic [6:0] addr;
    logic       rnw;
    logic [7:0] data;
    logic       ack_en;
    logic [8:0] sda_in;
  } i2c_cmd_t;

  typedef struct {
    logic       scl;
    logic       sda;
    logic       ack_rx;
    logic [7:0] rdata;
    logic       fin;
  } bus_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = 2'd0;
  logic [6:0]  slave_address = 7'd0;
  logic        read_not_write = 1'b0;
  logic [7:0]  tx_byte = 8'd0;
  logic        send_ack = 1'b0;
  logic [8:0]  bus_sda = 9'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl_level;
  logic        sda_level;
  logic        ack_received;
  logic [7:0]  read_data;
  logic        last;

  i2c_cmd_t   cmd_pending_q[$];
  bus_phase_t phase_expect_q[$];
  logic [7:0] hold_cfg = HOLD_RESET;
  int         err_count = 0;
  bit         in_sent = 1'b0;
  int         burst_left = 4;
  int         gap_left = 0;
  logic [15:0] ready_pat = 16'hFFFF;
  int         pat_left = 0;

  i2c_master_byte_engine_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .slave_address(slave_address), .read_not_write(read_not_write),
    .tx_byte(tx_byte), .send_ack(send_ack), .bus_sda(bus_sda),
    .out_valid(out_valid), .out_ready(out_ready),
    .scl_level(scl_level), .sda_level(sda_level), .ack_received(ack_received),
    .read_data(read_data), .last(last)
  );

  always #5 clk = ~clk;

  function automatic void add_phase(logic scl, logic sda);
    bus_phase_t p;
    p.scl = scl;
    p.sda = sda;
    p.ack_rx = 1'b0;
    p.rdata = 8'h00;
    p.fin = 1'b0;
    phase_expect_q.push_back(p);
  endfunction

  function automatic void close_command(logic ack, logic [7:0] rd);
    bus_phase_t p;
    p = phase_expect_q.pop_back();
    p.ack_rx = ack;
    p.rdata = rd;
    p.fin = 1'b1;
    phase_expect_q.push_back(p);
  endfunction

  function automatic void shift_octet(logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      add_phase(1'b0, b[i]);
      add_phase(1'b1, b[i]);
    end
    add_phase(1'b0, 1'b1);
    add_phase(1'b1, 1'b1);
  endfunction

  function automatic void predict_phases(i2c_cmd_t c);
    case (c.kind)
      CMD_START: begin
        add_phase(1'b1, 1'b1);
        add_phase(1'b1, 1'b0);
        shift_octet({c.addr, c.rnw});
        close_command(c.sda_in[8], 8'h00);
      end
      CMD_WRITE: begin
        shift_octet(c.data);
        close_command(c.sda_in[8], 8'h00);
      end
      CMD_READ: begin
        for (int i = 0; i < 8; i++) begin
          add_phase(1'b0, 1'b1);
          add_phase(1'b1, 1'b1);
        end
        add_phase(1'b0, !c.ack_en);
        add_phase(1'b1, !c.ack_en);
        add_phase(1'b0, 1'b1);
        close_command(1'b0, c.sda_in[7:0]);
      end
      default: begin
        add_phase(1'b0, 1'b0);
        add_phase(1'b1, 1'b0);
        add_phase(1'b1, 1'b1);
        close_command(1'b0, 8'h00);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  function automatic i2c_cmd_t random_cmd(cmd_t k);
    i2c_cmd_t c;
    c.kind = k;
    c.addr = 7'($urandom_range(0, 127));
    c.rnw = 1'($urandom_range(0, 1));
    c.data = 8'($urandom_range(0, 255));
    c.ack_en = 1'($urandom_range(0, 1));
    c.sda_in = 9'($urandom_range(0, 511));
    return c;
  endfunction

  task automatic queue_cmd(cmd_t k, logic [6:0] a, logic r, logic [7:0] d, logic ak,
                           logic [8:0] s);
    i2c_cmd_t c;
    c.kind = k;
    c.addr = a;
    c.rnw = r;
    c.data = d;
    c.ack_en = ak;
    c.sda_in = s;
    cmd_pending_q.push_back(c);
  endtask

  task automatic queue_traffic(int n);
    int cnt;
    int k;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) == 0) begin
        cmd_pending_q.push_back(random_cmd(cmd_t'($urandom_range(0, 3))));
        cnt++;
      end else begin
        k = $urandom_range(1, 4);
        cmd_pending_q.push_back(random_cmd(CMD_START));
        for (int i = 0; i < k; i++)
          cmd_pending_q.push_back(random_cmd($urandom_range(0, 1) ? CMD_READ : CMD_WRITE));
        cmd_pending_q.push_back(random_cmd(CMD_STOP));
        cnt += k + 2;
      end
    end
  endtask

  task automatic apb_xfer(logic wr, logic [31:0] wd, output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_PHASE_HOLD;
    pwdata <= wd;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_hold_reg();
    logic [31:0] rd;
    apb_xfer(1'b0, 32'd0, rd);
    if (rd !== {24'd0, hold_cfg}) begin
      $error("phase_hold_ticks: expected %0h, got %0h", hold_cfg, rd);
      err_count++;
    end
  endtask

  task automatic drain();
    while (cmd_pending_q.size() > 0 || in_valid || phase_expect_q.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_hold(logic [7:0] v);
    logic [31:0] rd;
    drain();
    apb_xfer(1'b1, {24'd0, v}, rd);
    hold_cfg = v;
    check_hold_reg();
  endtask

  // command driver
  always @(negedge clk) begin : drive_cmd
    i2c_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_sent) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_pending_q.size() > 0) begin
        nxt = cmd_pending_q.pop_front();
        cmd <= nxt.kind;
        slave_address <= nxt.addr;
        read_not_write <= nxt.rnw;
        tx_byte <= nxt.data;
        send_ack <= nxt.ack_en;
        bus_sda <= nxt.sda_in;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
          gap_left = $urandom_range(0, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // phase receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        ready_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        pat_left = $urandom_range(16, 96);
      end else begin
        ready_pat = {ready_pat[14:0], ready_pat[15]};
        pat_left--;
      end
      out_ready <= ready_pat[0];
    end
  end

  always @(posedge clk) begin : observe
    bus_phase_t want;
    i2c_cmd_t got;
    in_sent = !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (phase_expect_q.size() == 0) begin
        $error("unexpected phase beat: scl=%0b sda=%0b last=%0b",
               scl_level, sda_level, last);
        err_count++;
      end else begin
        want = phase_expect_q.pop_front();
        check_field("scl_level", 8'(want.scl), 8'(scl_level));
        check_field("sda_level", 8'(want.sda), 8'(sda_level));
        check_field("ack_received", 8'(want.ack_rx), 8'(ack_received));
        check_field("read_data", want.rdata, read_data);
        check_field("last", 8'(want.fin), 8'(last));
      end
    end
    if (in_sent) begin
      got.kind = cmd_t'(cmd);
      got.addr = slave_address;
      got.rnw = read_not_write;
      got.data = tx_byte;
      got.ack_en = send_ack;
      got.sda_in = bus_sda;
      predict_phases(got);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_hold_reg();

    // stop with no start, and stop back to back
    queue_cmd(CMD_STOP, 7'h7F, 1'b1, 8'hFF, 1'b1, 9'h1FF);
    queue_cmd(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 9'h000);
    queue_cmd(CMD_WRITE, 7'h7F, 1'b1, 8'h00, 1'b1, 9'h000);
    queue_cmd(CMD_START, 7'h00, 1'b0, 8'hFF, 1'b1, 9'h000);
    queue_cmd(CMD_START, 7'h7F, 1'b1, 8'h00, 1'b0, 9'h1FF);
    queue_cmd(CMD_START, 7'h55, 1'b0, 8'h00, 1'b0, 9'h100);
    queue_cmd(CMD_START, 7'h2A, 1'b1, 8'h00, 1'b0, 9'h0FF);
    queue_cmd(CMD_READ, 7'h7F, 1'b1, 8'hFF, 1'b1, 9'h000);
    queue_cmd(CMD_READ, 7'h00, 1'b0, 8'h00, 1'b0, 9'h1FF);
    queue_cmd(CMD_READ, 7'h00, 1'b0, 8'h00, 1'b1, 9'h0FF);
    queue_cmd(CMD_READ, 7'h00, 1'b0, 8'h00, 1'b0, 9'h15A);
    queue_cmd(CMD_WRITE, 7'h00, 1'b0, 8'h00, 1'b0, 9'h000);
    queue_cmd(CMD_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0, 9'h1FF);
    queue_cmd(CMD_WRITE, 7'h7F, 1'b1, 8'hA5, 1'b1, 9'h0FF);
    queue_cmd(CMD_WRITE, 7'h00, 1'b0, 8'h5A, 1'b0, 9'h100);
    queue_cmd(CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 9'h000);
    queue_cmd(CMD_READ, 7'h00, 1'b0, 8'h00, 1'b1, 9'h1A5);
    queue_cmd(CMD_START, 7'h7F, 1'b1, 8'hFF, 1'b1, 9'h0FF);
    queue_cmd(CMD_STOP, 7'h7F, 1'b1, 8'hFF, 1'b1, 9'h1FF);
    queue_traffic(60);

    program_hold(8'd1);
    queue_traffic(150);
    program_hold(8'd255);
    queue_traffic(4);
    program_hold(8'd2);
    queue_traffic(120);
    program_hold(8'($urandom_range(3, 12)));
    queue_traffic(80);

    drain();
    repeat (300) @(posedge clk);
    if (err_count == 0 && phase_expect_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
